FILE: hw/rtl/bpc_pkg.sv
// Shared types and constants for the barometer pressure compensation pipeline.
package bpc_pkg;

	// Field widths of one sample beat and one result beat.
	localparam int unsigned RawW   = 24;
	localparam int unsigned PressW = 27;
	localparam int unsigned TempW  = 20;
	localparam int unsigned CoefW  = 16;

	// Internal widths: temperature delta, coefficient products, offset and sensitivity.
	localparam int unsigned DtW   = RawW + 1;
	localparam int unsigned ProdW = DtW + CoefW + 1;
	localparam int unsigned AccW  = 40;

	// Configuration register map.
	localparam int unsigned NumCoefs  = 6;
	localparam int unsigned PaddrW    = 5;
	localparam int unsigned ApbDataW  = 32;

	typedef enum logic [2:0] {
		REG_SENS_BASE   = 3'd0,
		REG_OFFSET_BASE = 3'd1,
		REG_SENS_TC     = 3'd2,
		REG_OFFSET_TC   = 3'd3,
		REG_REF_TEMP    = 3'd4,
		REG_TEMP_SENS   = 3'd5
	} reg_idx_t;

	// Compensation thresholds and weights.
	localparam logic signed [TempW-1:0] TempRef   = 20'sd2000;
	localparam logic signed [19:0]      ColdShift = 20'sd3500;
	localparam logic signed [18:0]      ColdLimit = -19'sd3500;
	localparam int unsigned             OffWeight = 61;
	localparam int unsigned             OffCold   = 15;

	typedef struct packed {
		logic [RawW-1:0] raw_pressure;
		logic [RawW-1:0] raw_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [PressW-1:0] pressure_out;
		logic signed [TempW-1:0]  temperature_out;
	} result_t;

	typedef struct packed {
		logic [CoefW-1:0] sens_base;
		logic [CoefW-1:0] offset_base;
		logic [CoefW-1:0] sens_tc;
		logic [CoefW-1:0] offset_tc;
		logic [CoefW-1:0] ref_temp;
		logic [CoefW-1:0] temp_sens;
	} coef_t;

	// Beat handed from the temperature front end to the pressure back end.
	typedef struct packed {
		logic                    valid;
		logic [RawW-1:0]         d1;
		logic signed [TempW-1:0] temp;
		logic [17:0]             t2;
		logic [37:0]             sq;
		logic [39:0]             r;
		logic signed [AccW-1:0]  off_base;
		logic signed [AccW-1:0]  sens_base;
	} front_t;

endpackage

FILE: hw/rtl/bpc_cfg_regs.sv
// Calibration coefficient register file behind an APB-style port.
module bpc_cfg_regs
	import bpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PaddrW-1:0]   paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready,
	output coef_t               coef
);

	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[PaddrW-1:2]);

	// Register writes; indexes past the map are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_SENS_BASE:   coef.sens_base   <= pwdata[CoefW-1:0];
				REG_OFFSET_BASE: coef.offset_base <= pwdata[CoefW-1:0];
				REG_SENS_TC:     coef.sens_tc     <= pwdata[CoefW-1:0];
				REG_OFFSET_TC:   coef.offset_tc   <= pwdata[CoefW-1:0];
				REG_REF_TEMP:    coef.ref_temp    <= pwdata[CoefW-1:0];
				REG_TEMP_SENS:   coef.temp_sens   <= pwdata[CoefW-1:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_SENS_BASE:   prdata[CoefW-1:0] = coef.sens_base;
			REG_OFFSET_BASE: prdata[CoefW-1:0] = coef.offset_base;
			REG_SENS_TC:     prdata[CoefW-1:0] = coef.sens_tc;
			REG_OFFSET_TC:   prdata[CoefW-1:0] = coef.offset_tc;
			REG_REF_TEMP:    prdata[CoefW-1:0] = coef.ref_temp;
			REG_TEMP_SENS:   prdata[CoefW-1:0] = coef.temp_sens;
			default:         prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/bpc_front.sv
// Stages one to three: temperature delta, coefficient products, temperature and squares.
module bpc_front
	import bpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  sample_t sample,
	input  coef_t   coef,
	output front_t  front
);

	// Stage 1 registers.
	logic                   v_s1;
	logic [RawW-1:0]        d1_s1;
	logic signed [DtW-1:0]  dt_s1;
	// Stage 2 registers.
	logic                   v_s2;
	logic [RawW-1:0]        d1_s2;
	logic signed [ProdW-1:0] pt_s2, poff_s2, psens_s2;
	logic [17:0]            t2_s2;
	// Stage 3 combinational terms.
	logic signed [18:0]     q;
	logic signed [19:0]     qa;
	logic signed [37:0]     qsq;
	logic signed [39:0]     qasq;
	logic signed [2*DtW-1:0] dtsq;
	logic                   cold, very_cold;
	logic signed [35:0]     off_tc;
	logic signed [34:0]     sens_tc;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: dT = D2 - C5 * 256.
	always_ff @(posedge clk) begin
		d1_s1 <= sample.raw_pressure;
		dt_s1 <= $signed({1'b0, sample.raw_temperature})
			- $signed({1'b0, coef.ref_temp, 8'd0});
	end

	// Stage 2: products of dT with the coefficients and with itself.
	assign dtsq = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		d1_s2    <= d1_s1;
		pt_s2    <= dt_s1 * $signed({1'b0, coef.temp_sens});
		poff_s2  <= dt_s1 * $signed({1'b0, coef.offset_tc});
		psens_s2 <= dt_s1 * $signed({1'b0, coef.sens_tc});
		t2_s2    <= dtsq[48:31];
	end

	// Stage 3: first-order temperature, offset and sensitivity, and the correction squares.
	assign q         = pt_s2[ProdW-1:23];
	assign qa        = {q[18], q} + ColdShift;
	assign qsq       = q * q;
	assign qasq      = qa * qa;
	assign cold      = q[18];
	assign very_cold = q < ColdLimit;
	assign off_tc    = poff_s2[ProdW-1:6];
	assign sens_tc   = psens_s2[ProdW-1:7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front <= '0;
		end else begin
			front.valid <= v_s2;
			front.d1   <= d1_s2;
			front.temp <= {q[18], q} + TempRef;
			front.t2   <= cold ? t2_s2 : '0;
			front.sq   <= cold ? qsq[37:0] : '0;
			front.r    <= very_cold ? qasq[39:0] : '0;
			front.off_base <= $signed({7'd0, coef.offset_base, 17'd0})
				+ {{(AccW-36){off_tc[35]}}, off_tc};
			front.sens_base <= $signed({8'd0, coef.sens_base, 16'd0})
				+ {{(AccW-35){sens_tc[34]}}, sens_tc};
		end
	end

endmodule

FILE: hw/rtl/bpc_back.sv
// Stages four to seven: second-order correction and the split pressure product.
module bpc_back
	import bpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  front_t  front,
	output logic    done,
	output result_t result
);

	// Stage 4 registers.
	logic                    v_s4;
	logic [RawW-1:0]         d1_s4;
	logic signed [AccW-1:0]  off_s4, sens_s4;
	logic signed [TempW-1:0] temp_s4;
	// Stage 5 registers.
	logic                    v_s5;
	logic [43:0]             pl_s5;
	logic signed [43:0]      ph_s5;
	logic signed [AccW-1:0]  off_s5;
	logic signed [TempW-1:0] temp_s5;
	// Stage 6 registers.
	logic                    v_s6;
	logic signed [42:0]      p21_s6;
	logic signed [AccW-1:0]  off_s6;
	logic signed [TempW-1:0] temp_s6;
	// Combinational terms.
	logic [43:0]             off2, sens2;
	logic signed [63:0]      prod;
	logic signed [43:0]      diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s4 <= front.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			done <= v_s6;
		end
	end

	// Stage 4: offset and sensitivity corrections; the square is shifted before weighting.
	assign off2  = 44'(front.sq[37:4]) * 44'(OffWeight) + 44'(front.r) * 44'(OffCold);
	assign sens2 = {5'd0, front.sq, 1'b0} + {1'b0, front.r, 3'd0};

	always_ff @(posedge clk) begin
		d1_s4   <= front.d1;
		off_s4  <= front.off_base - $signed(off2[AccW-1:0]);
		sens_s4 <= front.sens_base - $signed(sens2[AccW-1:0]);
		temp_s4 <= front.temp - $signed({2'd0, front.t2});
	end

	// Stage 5: D1 times sensitivity as two partial products; the high one fits 44 bits.
	always_ff @(posedge clk) begin
		pl_s5   <= d1_s4 * sens_s4[19:0];
		ph_s5   <= $signed({1'b0, d1_s4}) * $signed(sens_s4[AccW-1:20]);
		off_s5  <= off_s4;
		temp_s5 <= temp_s4;
	end

	// Stage 6: combine the partial products and drop 21 fraction bits.
	assign prod = $signed({ph_s5, 20'd0}) + $signed({20'd0, pl_s5});

	always_ff @(posedge clk) begin
		p21_s6  <= prod[63:21];
		off_s6  <= off_s5;
		temp_s6 <= temp_s5;
	end

	// Stage 7: subtract the offset, scale down by 2^15 and register the result beat.
	assign diff = {p21_s6[42], p21_s6} - {{(44-AccW){off_s6[AccW-1]}}, off_s6};

	always_ff @(posedge clk) begin
		result.pressure_out    <= diff[PressW+14:15];
		result.temperature_out <= temp_s6;
	end

endmodule

FILE: hw/rtl/barometer_pressure_compensation.sv
// Top level of the barometer pressure compensation pipeline.
// Throughput: one sample per cycle; busy stays low, so start may be held every cycle.
// An accepted sample exits the seven-stage multiply pipeline with its result strobe on
// done; results cannot be stalled. Reset (arst_n low) clears the pipeline valid bits
// and all coefficients to zero. The user writes coefficients over the APB-style port
// only while no beat is in flight; the block itself does not enforce this.
module barometer_pressure_compensation
	import bpc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sample_t             sample,
	output logic                done,
	output result_t             result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PaddrW-1:0]   paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready
);

	coef_t  coef;
	front_t front;

	// The pipeline takes a beat every cycle.
	assign busy = 1'b0;

	bpc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	bpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.sample   (sample),
		.coef     (coef),
		.front    (front)
	);

	bpc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.front  (front),
		.done   (done),
		.result (result)
	);

endmodule

FILE: hw/rtl/bpc_checker.sv
// Port-level checker for the barometer pressure compensation pipeline and its bind.
module bpc_checker
	import bpc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [ApbDataW-1:0] prdata,
	input logic                pready
);

	// Every accepted beat yields a strobe on done as it leaves the pipeline.
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##7 done)
		else $error("accepted beat gave no result strobe");

	// No strobe on done without a matching earlier accepted beat.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7) && !$past(busy, 7))
		else $error("result strobe without an accepted beat");

	// The pipeline never pushes back on the sender.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Coefficients are 16 bits, so read data above them is zero.
	a_prdata_upper: assert property (@(posedge clk) disable iff (!arst_n)
		pready |-> prdata[ApbDataW-1:CoefW] == '0)
		else $error("read data above the coefficient width");

endmodule

bind barometer_pressure_compensation bpc_checker u_bpc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.prdata (prdata),
	.pready (pready)
);
